### rtl/esp3pd_pkg.sv
// ----------------------------------------------------------------------------
// esp3pd_pkg
// Types, codes and the CRC-8 update shared by the packet deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package esp3pd_pkg;

  localparam logic [7:0] SyncByte = 8'h55;
  localparam logic [7:0] CrcPoly  = 8'h07;
  localparam logic [7:0] CrcInit  = 8'h00;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_HCRC   = 3'd2,
    PH_DATA   = 3'd3,
    PH_OPT    = 3'd4,
    PH_DCRC   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_OPT      = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_DCRC_BAD = 3'd3,
    KIND_HCRC_BAD = 3'd4,
    KIND_SKIP     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    HPOS_LEN_HI = 2'd0,
    HPOS_LEN_LO = 2'd1,
    HPOS_OPT    = 2'd2,
    HPOS_TYPE   = 2'd3
  } hpos_e;

  typedef struct packed {
    phase_e      phase;
    hpos_e       hpos;
    logic [15:0] data_size;
    logic [7:0]  opt_len;
    logic [7:0]  pkt_type;
    logic [7:0]  crc;
    logic [15:0] remain;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [7:0]  frame_type;
    logic [15:0] frame_data_length;
    logic [7:0]  frame_optional_length;
  } result_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/esp3pd_if.sv
// ----------------------------------------------------------------------------
// esp3pd_if
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface esp3pd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface esp3pd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [7:0]  byte_value;
  logic [7:0]  frame_type;
  logic [15:0] frame_data_length;
  logic [7:0]  frame_optional_length;

  modport source (
    output valid, output item_kind, output byte_value, output frame_type,
    output frame_data_length, output frame_optional_length, input ready
  );
  modport sink (
    input valid, input item_kind, input byte_value, input frame_type,
    input frame_data_length, input frame_optional_length, output ready
  );
endinterface

`default_nettype wire

### rtl/esp3pd_step.sv
// ----------------------------------------------------------------------------
// esp3pd_step
// Next-state and result logic of the deframer for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module esp3pd_step (
  input  esp3pd_pkg::state_t  state_i,
  input  logic [7:0]          rx_byte_i,
  output esp3pd_pkg::state_t  state_o,
  output logic                emit_o,
  output esp3pd_pkg::result_t result_o
);
  import esp3pd_pkg::*;

  state_t      ns;
  kind_e       kind;
  logic [15:0] remain_dec;

  assign remain_dec = state_i.remain - 16'd1;

  always_comb begin
    ns     = state_i;
    emit_o = 1'b0;
    kind   = KIND_SKIP;
    case (state_i.phase)
      PH_HEADER: begin
        ns.crc = crc8_next(state_i.crc, rx_byte_i);
        case (state_i.hpos)
          HPOS_LEN_HI: ns.data_size[15:8] = rx_byte_i;
          HPOS_LEN_LO: ns.data_size[7:0]  = rx_byte_i;
          HPOS_OPT:    ns.opt_len         = rx_byte_i;
          default:     ns.pkt_type        = rx_byte_i;
        endcase
        if (state_i.hpos == HPOS_TYPE) begin
          ns.hpos  = HPOS_LEN_HI;
          ns.phase = PH_HCRC;
        end else begin
          ns.hpos = hpos_e'(state_i.hpos + 2'd1);
        end
      end
      PH_HCRC: begin
        if (rx_byte_i != state_i.crc) begin
          ns.phase = PH_HUNT;
          emit_o   = 1'b1;
          kind     = KIND_HCRC_BAD;
        end else begin
          ns.crc = CrcInit;
          if (state_i.data_size != 16'd0) begin
            ns.phase  = PH_DATA;
            ns.remain = state_i.data_size;
          end else if (state_i.opt_len != 8'd0) begin
            ns.phase  = PH_OPT;
            ns.remain = {8'd0, state_i.opt_len};
          end else begin
            ns.phase  = PH_DCRC;
            ns.remain = 16'd0;
          end
        end
      end
      PH_DATA: begin
        ns.crc    = crc8_next(state_i.crc, rx_byte_i);
        ns.remain = remain_dec;
        if (remain_dec == 16'd0) begin
          if (state_i.opt_len != 8'd0) begin
            ns.phase  = PH_OPT;
            ns.remain = {8'd0, state_i.opt_len};
          end else begin
            ns.phase  = PH_DCRC;
            ns.remain = 16'd0;
          end
        end
        emit_o = 1'b1;
        kind   = KIND_DATA;
      end
      PH_OPT: begin
        ns.crc    = crc8_next(state_i.crc, rx_byte_i);
        ns.remain = remain_dec;
        if (remain_dec == 16'd0) begin
          ns.phase = PH_DCRC;
        end
        emit_o = 1'b1;
        kind   = KIND_OPT;
      end
      PH_DCRC: begin
        ns.phase = PH_HUNT;
        emit_o   = 1'b1;
        kind     = (rx_byte_i == state_i.crc) ? KIND_GOOD : KIND_DCRC_BAD;
      end
      default: begin
        if (rx_byte_i == SyncByte) begin
          ns.phase = PH_HEADER;
          ns.hpos  = HPOS_LEN_HI;
          ns.crc   = CrcInit;
        end else begin
          ns.phase = PH_HUNT;
          emit_o   = 1'b1;
          kind     = KIND_SKIP;
        end
      end
    endcase
  end

  assign state_o = ns;

  always_comb begin
    result_o.kind                  = kind;
    result_o.byte_value            = rx_byte_i;
    result_o.frame_type            = ns.pkt_type;
    result_o.frame_data_length     = ns.data_size;
    result_o.frame_optional_length = ns.opt_len;
  end

endmodule

`default_nettype wire

### rtl/esp3_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// esp3_packet_deframer_core
// Serial packet deframer: sync hunt, header with CRC-8, tagged data and
// optional bytes, closing CRC-8 status.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  rx_i     in   rx_byte
//  res_o    out  item_kind, byte_value, frame_type, frame_data_length,
//                frame_optional_length
//
//  One byte per cycle while rx_i is ready; any result of a byte is registered.
//  The CRC update is one 8-step XOR chain per byte.
//  Reset returns the frame state to sync hunt with all header fields zero.
//  rx_i is ready while the output register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module esp3_packet_deframer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  esp3pd_in_if.sink           rx_i,
  esp3pd_out_if.source        res_o
);
  import esp3pd_pkg::*;

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    emit;
  logic    rx_xfer;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_xfer    = rx_i.valid && rx_i.ready;

  esp3pd_step u_step (
    .state_i   (state_q),
    .rx_byte_i (rx_i.rx_byte),
    .state_o   (state_d),
    .emit_o    (emit),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_HUNT, hpos: HPOS_LEN_HI, default: '0};
      res_valid_q <= 1'b0;
    end else begin
      if (rx_xfer) begin
        state_q     <= state_d;
        res_valid_q <= emit;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_xfer && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid                 = res_valid_q;
  assign res_o.item_kind             = res_q.kind;
  assign res_o.byte_value            = res_q.byte_value;
  assign res_o.frame_type            = res_q.frame_type;
  assign res_o.frame_data_length     = res_q.frame_data_length;
  assign res_o.frame_optional_length = res_q.frame_optional_length;

endmodule

`default_nettype wire
